[rtl/core/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Transaction payloads, entry layout, sizes and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	// table size and key width in use
	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 16;

	// field widths fixed by the interface
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 32;
	localparam int CAP_W   = 5;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
	localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(1);

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic                      op;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
	} rsp_t;

	// one entry as held in the table memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// outcome of one pass over the table
	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic [VALUE_W-1:0] hit_value;
		logic [COUNT_W-1:0] hit_count;
		logic               victim_found;
		logic [IDX_W-1:0]   victim_idx;
		logic               free_found;
		logic [IDX_W-1:0]   free_idx;
	} scan_t;

	// saturating increment for counts and the time stamp
	function automatic logic [31:0] sat_inc32(input logic [31:0] x);
		return (x == '1) ? x : x + 32'd1;
	endfunction

	// keep only the low KEY_BITS bits of a key
	function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] m;
		m = k;
		for (int i = 0; i < KEY_W; i++) begin
			if (i >= KEY_BITS) begin
				m[i] = 1'b0;
			end
		end
		return m;
	endfunction

	// capacity limited to the table size
	function automatic logic [OCC_W-1:0] cap_limit(input logic [CAP_W-1:0] c);
		int ci;
		ci = int'(c);
		if (ci > ENTRIES) begin
			ci = ENTRIES;
		end
		return OCC_W'(ci);
	endfunction

endpackage

`default_nettype wire

[rtl/core/lfu_entry_ram.sv]
// ----------------------------------------------------------------------------
// lfu_entry_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_entry_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 112,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/lfu_scan.sv]
// ----------------------------------------------------------------------------
// lfu_scan: per-entry accumulator for one pass over the table
// Tracks the key match, the LFU victim (oldest stamp on ties) and the
// lowest free slot as entries stream out of the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_scan (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clear,
	input  wire logic                      sample,
	input  wire logic [lfu_pkg::IDX_W-1:0] idx,
	input  wire logic                      slot_valid,
	input  wire lfu_pkg::entry_t           entry,
	input  wire logic [lfu_pkg::KEY_W-1:0] key,
	output lfu_pkg::scan_t                 result
);

	lfu_pkg::scan_t                res_q;
	logic [lfu_pkg::COUNT_W-1:0]   best_count_q;
	logic [lfu_pkg::STAMP_W-1:0]   best_stamp_q;
	logic                          match;
	logic                          better;

	// compare the entry just read against the running results
	always_comb begin
		match  = slot_valid && (entry.key == key);
		better = slot_valid && (!res_q.victim_found ||
			(entry.count < best_count_q) ||
			((entry.count == best_count_q) && (entry.stamp < best_stamp_q)));
	end

	// running results: flags cleared per transaction, payload follows the flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q        <= '0;
			best_count_q <= '0;
			best_stamp_q <= '0;
		end else if (clear) begin
			res_q.hit          <= 1'b0;
			res_q.victim_found <= 1'b0;
			res_q.free_found   <= 1'b0;
		end else if (sample) begin
			if (match && !res_q.hit) begin
				res_q.hit       <= 1'b1;
				res_q.hit_idx   <= idx;
				res_q.hit_value <= entry.value;
				res_q.hit_count <= entry.count;
			end
			if (better) begin
				res_q.victim_found <= 1'b1;
				res_q.victim_idx   <= idx;
				best_count_q       <= entry.count;
				best_stamp_q       <= entry.stamp;
			end
			if (!slot_valid && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx;
			end
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire

[rtl/core/lfu_cache_table.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table: key-value cache with least-frequently-used replacement
// Request channel (req_valid/req_stall, payload req) carries get and put
// transactions; response channel (rsp_valid/rsp_stall, payload rsp) returns
// one transaction per get and none per put. cfg_valid/cfg_ready writes the
// capacity register; write it only while the block is idle.
//
// Each request is served alone: an accept step, a pass reading every entry of the
// entry memory (key match, victim and free slot found in the same pass), a drain
// step for the last read data and a write-back step. The single read port of the
// entry memory makes the pass read the entries one after another. A get's
// response appears in the cycle after the write-back. With capacity zero a
// request skips the pass.
//
// A result waiting on a stalled response channel does not block the next request;
// only a following get's write-back waits until the response register frees up.
// Reset clears all valid bits, the occupancy, the time and sets capacity to
// 16; the memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire lfu_pkg::req_t             req,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output lfu_pkg::rsp_t                  rsp,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [lfu_pkg::CAP_W-1:0] cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [lfu_pkg::IDX_W-1:0] LAST_IDX = lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1);

	logic [1:0]                    state_q;
	logic [lfu_pkg::CAP_W-1:0]     capacity_q;
	logic [lfu_pkg::OCC_W-1:0]     occ_q;
	logic [lfu_pkg::STAMP_W-1:0]   time_q;
	logic [lfu_pkg::ENTRIES-1:0]   valid_q;
	logic [lfu_pkg::IDX_W-1:0]     addr_q;

	logic                          op_q;
	logic [lfu_pkg::KEY_W-1:0]     key_q;
	logic [lfu_pkg::VALUE_W-1:0]   value_q;
	logic                          dis_q;
	logic [lfu_pkg::OCC_W-1:0]     cap_q;

	logic                          smp_s1;
	logic [lfu_pkg::IDX_W-1:0]     idx_s1;

	logic                          rsp_valid_q;
	lfu_pkg::rsp_t                 rsp_q;

	logic                          accept;
	logic [lfu_pkg::OCC_W-1:0]     cap_eff;
	lfu_pkg::entry_t               rd_entry;
	lfu_pkg::scan_t                scan;

	logic                          fin;
	logic                          wr_en;
	logic [lfu_pkg::IDX_W-1:0]     wr_addr;
	lfu_pkg::entry_t               wr_entry;
	logic                          set_en;
	logic                          clr_en;
	logic                          occ_inc;
	logic                          rsp_load;
	lfu_pkg::rsp_t                 rsp_next;
	logic                          evict;
	logic [lfu_pkg::IDX_W-1:0]     tgt_idx;
	logic                          tgt_ok;
	logic [lfu_pkg::ENTRIES-1:0]   valid_nxt;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign cap_eff   = lfu_pkg::cap_limit(capacity_q);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lfu_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// entry memory
	lfu_entry_ram #(
		.DEPTH(lfu_pkg::ENTRIES),
		.WIDTH(lfu_pkg::ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.raddr(addr_q),
		.rdata(rd_entry)
	);

	// pass over the table
	lfu_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.sample    (smp_s1),
		.idx       (idx_s1),
		.slot_valid(valid_q[idx_s1]),
		.entry     (rd_entry),
		.key       (key_q),
		.result    (scan)
	);

	// write-back decision at the end of the pass
	always_comb begin
		fin      = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = scan.hit_idx;
		wr_entry = '{key: key_q, value: value_q,
			count: lfu_pkg::sat_inc32(scan.hit_count), stamp: time_q};
		set_en   = 1'b0;
		clr_en   = 1'b0;
		occ_inc  = 1'b0;
		rsp_load = 1'b0;
		rsp_next = '{found: 1'b0, read_value: lfu_pkg::MISS_VALUE};
		evict    = (occ_q >= cap_q) && scan.victim_found;
		tgt_idx  = scan.free_idx;
		if (evict && (!scan.free_found || (scan.victim_idx < scan.free_idx))) begin
			tgt_idx = scan.victim_idx;
		end
		tgt_ok = evict || scan.free_found;

		if (state_q == ST_FIN) begin
			fin = (op_q == lfu_pkg::OP_PUT) || !rsp_valid_q || !rsp_stall;
		end

		if (fin) begin
			if (op_q == lfu_pkg::OP_GET) begin
				rsp_load = 1'b1;
				if (!dis_q && scan.hit) begin
					rsp_next.found      = 1'b1;
					rsp_next.read_value = scan.hit_value;
					wr_en               = 1'b1;
					wr_entry.value      = scan.hit_value;
				end
			end else if (!dis_q) begin
				if (scan.hit) begin
					wr_en = 1'b1;
				end else begin
					clr_en = evict;
					if (tgt_ok) begin
						wr_en          = 1'b1;
						wr_addr        = tgt_idx;
						wr_entry.count = lfu_pkg::COUNT_INIT;
						set_en         = 1'b1;
						occ_inc        = !evict;
					end
				end
			end
		end

		// victim slot freed first, then the target slot taken
		valid_nxt = valid_q;
		if (clr_en) begin
			valid_nxt[scan.victim_idx] = 1'b0;
		end
		if (set_en) begin
			valid_nxt[tgt_idx] = 1'b1;
		end
	end

	// sequencer, time, occupancy and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			time_q  <= '0;
			occ_q   <= '0;
			valid_q <= '0;
			smp_s1  <= 1'b0;
			dis_q   <= 1'b0;
		end else begin
			smp_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q <= '0;
						dis_q  <= (cap_eff == '0);
						if (cap_eff == '0) begin
							state_q <= ST_FIN;
						end else begin
							time_q  <= lfu_pkg::sat_inc32(time_q);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (clr_en || set_en) begin
				valid_q <= valid_nxt;
			end
			if (occ_inc) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	// request payload and read pipeline index
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (accept) begin
			op_q    <= req.op;
			key_q   <= lfu_pkg::mask_key(req.key);
			value_q <= req.value;
			cap_q   <= cap_eff;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/core/lfu_checker.sv]
// ----------------------------------------------------------------------------
// lfu_checker: port-level checks of the LFU cache table
// Watches the request, response and configuration ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_stall,
	input wire lfu_pkg::req_t             req,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_stall,
	input wire lfu_pkg::rsp_t             rsp,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready,
	input wire logic [lfu_pkg::CAP_W-1:0] cfg_data
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// a miss always reads as all ones
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == lfu_pkg::MISS_VALUE)
		else $error("miss with a value other than all ones");

	// a new response follows a cycle in which a request was in progress
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a request in progress");

	// a capacity write is always taken and carries known data
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
		else $error("capacity write refused or unknown");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (.*);

`default_nettype wire
